// ===== hw/rtl/iiht_pkg.sv =====
// ----------------------------------------------------------------------------
// iiht_pkg
// Shared types and helpers for the identifier intern hash table.
// ----------------------------------------------------------------------------
package iiht_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam int         POSITION_W   = 10;
    localparam int         BUCKET_W     = 7;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic reduce;
        logic zero;
        logic head_take;
        logic next_take;
        logic cmp_start;
        logic cmp_next;
        logic hit;
        logic insert;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic hash_big;
        logic last;
        logic fail;
        logic head_v;
        logic len_eq;
        logic nv;
        logic ch_eq;
        logic cmp_end;
        logic out_free;
    } t_status;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            return c + (CHAR_LOWER_A - CHAR_UPPER_A);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/identifier_intern_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// identifier_intern_hash_table_unit
// Case-insensitive identifier interning with a chained hash table.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                | side
// s       | in  | char_code[7:0]                    | tlast = last_char
// m       | out | found, position[9:0], bucket[6:0] | tuser = status
//
// A non-final character is accepted and checked, with one bucket subtraction
// of the running sum per extra pass (at most three). A final character adds
// the zero-byte write, the head read, a read and a check per chain entry
// visited, a read and a compare per compared character, an insert on a miss
// and a finish that holds until the m side has room; a word that did not fit
// goes straight to the finish. After reset a clearing pass over all BUCKETS heads empties them before input is taken.
// ----------------------------------------------------------------------------
module identifier_intern_hash_table_unit
    import iiht_pkg::*;
#(
    parameter int STORE_CHARS = 1024,
    parameter int BUCKETS     = 100,
    parameter int MAX_ENTRIES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // char_code[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,  // found, position[9:0], bucket[6:0], zero pad
    output logic        m_tuser   // status
);

    t_cmd    cmd;
    t_status status;
    logic                  found;
    logic [POSITION_W-1:0] position;
    logic [BUCKET_W-1:0]   bucket;

    iiht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_status   (status),
        .o_in_ready (s_tready),
        .o_cmd      (cmd)
    );

    iiht_datapath #(
        .STORE_CHARS (STORE_CHARS),
        .BUCKETS     (BUCKETS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_char      (s_tdata),
        .i_last      (s_tlast),
        .i_out_ready (m_tready),
        .o_status    (status),
        .o_out_valid (m_tvalid),
        .o_found     (found),
        .o_position  (position),
        .o_bucket    (bucket),
        .o_fail      (m_tuser)
    );

    assign m_tdata = {6'd0, bucket, position, found};

endmodule

// ===== hw/rtl/iiht_ctrl.sv =====
// ----------------------------------------------------------------------------
// iiht_ctrl
// Sequencer for the clearing pass, hashing, chain walk, compare, insert and finish.
// ----------------------------------------------------------------------------
module iiht_ctrl
    import iiht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RED, ST_ZERO, ST_HEAD, ST_ERD,
        ST_ECHK, ST_CRD, ST_CCMP, ST_INS, ST_FIN
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_RED;
                end
            end
            ST_RED: begin
                if (i_status.hash_big) begin
                    o_cmd.reduce = 1'b1;
                end else if (!i_status.last) begin
                    n_state = ST_IDLE;
                end else if (i_status.fail) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_ZERO;
                end
            end
            ST_ZERO: begin
                o_cmd.zero = 1'b1;
                n_state    = ST_HEAD;
            end
            ST_HEAD: begin
                if (i_status.head_v) begin
                    o_cmd.head_take = 1'b1;
                    n_state         = ST_ERD;
                end else begin
                    n_state = ST_INS;
                end
            end
            ST_ERD: n_state = ST_ECHK;
            ST_ECHK: begin
                if (i_status.len_eq) begin
                    o_cmd.cmp_start = 1'b1;
                    n_state         = ST_CRD;
                end else if (i_status.nv) begin
                    o_cmd.next_take = 1'b1;
                    n_state         = ST_ERD;
                end else begin
                    n_state = ST_INS;
                end
            end
            ST_CRD: n_state = ST_CCMP;
            ST_CCMP: begin
                if (i_status.ch_eq) begin
                    if (i_status.cmp_end) begin
                        o_cmd.hit = 1'b1;
                        n_state   = ST_FIN;
                    end else begin
                        o_cmd.cmp_next = 1'b1;
                        n_state        = ST_CRD;
                    end
                end else if (i_status.nv) begin
                    o_cmd.next_take = 1'b1;
                    n_state         = ST_ERD;
                end else begin
                    n_state = ST_INS;
                end
            end
            ST_INS: begin
                o_cmd.insert = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.clr_done && o_cmd.clr_step |=> !o_cmd.clr_step)
        else $error("clear pass did not end");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_status.out_free)
        else $error("result loaded while output busy");
    a_hit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.hit |-> i_status.last && !i_status.fail)
        else $error("hit outside a word end");
`endif

endmodule

// ===== hw/rtl/iiht_datapath.sv =====
// ----------------------------------------------------------------------------
// iiht_datapath
// Character store, bucket heads, entry table, hash and result register.
// ----------------------------------------------------------------------------
module iiht_datapath
    import iiht_pkg::*;
#(
    parameter int STORE_CHARS = 1024,
    parameter int BUCKETS     = 100,
    parameter int MAX_ENTRIES = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [7:0]            i_char,
    input  logic                  i_last,
    input  logic                  i_out_ready,
    output t_status               o_status,
    output logic                  o_out_valid,
    output logic                  o_found,
    output logic [POSITION_W-1:0] o_position,
    output logic [BUCKET_W-1:0]   o_bucket,
    output logic                  o_fail
);

    localparam int AW = $clog2(STORE_CHARS);
    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int HW = $clog2(BUCKETS + 256);
    localparam int ENT_W = AW + (AW + 1) + EW + 1;

    logic [7:0]    r_store [STORE_CHARS];
    logic [EW:0]   r_heads [BUCKETS];
    logic [ENT_W-1:0] r_ents [MAX_ENTRIES];

    logic [HW-1:0] r_hash;
    logic [AW:0]   r_wp, r_wb, r_len, r_i, r_pos;
    logic          r_ovf, r_last, r_fail, r_hit;
    logic [EW:0]   r_count;
    logic [EW-1:0] r_e;
    logic [BW-1:0] r_clr;
    logic [EW:0]   r_head_q;
    logic [ENT_W-1:0] r_ent_q;
    logic [7:0]    r_qa, r_qb;
    logic          r_ovalid, r_found, r_stat;
    logic [AW:0]   r_opos;
    logic [HW-1:0] r_obkt;

    logic [AW-1:0] q_start;
    logic [AW:0]   q_len;
    logic [EW-1:0] q_next;
    logic          q_nv;
    logic [AW:0]   addr_a, addr_b;
    logic [BW-1:0] hidx;
    logic          out_free;
    logic [AW+POSITION_W:0] pos_ext;
    logic [HW+BUCKET_W-1:0] bkt_ext;

    assign {q_start, q_len, q_next, q_nv} = r_ent_q;
    assign addr_a   = {1'b0, q_start} + r_i;
    assign addr_b   = r_wb + r_i;
    assign hidx     = r_hash[BW-1:0];
    assign out_free = !r_ovalid || i_out_ready;

    assign o_status.clr_done = (r_clr == BW'(BUCKETS - 1));
    assign o_status.hash_big = (r_hash >= HW'(BUCKETS));
    assign o_status.last     = r_last;
    assign o_status.fail     = r_fail;
    assign o_status.head_v   = r_head_q[EW];
    assign o_status.len_eq   = (q_len == r_len);
    assign o_status.nv       = q_nv;
    assign o_status.ch_eq    = (fold_case(r_qa) == fold_case(r_qb));
    assign o_status.cmp_end  = ((r_i + 1'b1) == q_len);
    assign o_status.out_free = out_free;

    always_ff @(posedge i_clk) begin
        r_head_q <= r_heads[hidx];
        r_ent_q  <= r_ents[r_e];
        r_qa     <= r_store[addr_a[AW-1:0]];
        r_qb     <= r_store[addr_b[AW-1:0]];
        if (i_cmd.clr_step) r_heads[r_clr] <= '0;
        if (i_cmd.insert && r_count < (EW+1)'(MAX_ENTRIES)) begin
            r_heads[hidx]        <= {1'b1, r_count[EW-1:0]};
            r_ents[r_count[EW-1:0]] <= {r_wb[AW-1:0], r_len, r_head_q[EW-1:0], r_head_q[EW]};
        end
        if (i_cmd.accept) begin
            if (i_last) begin
                if (!(r_ovf || (r_wp + 1'b1) >= (AW+1)'(STORE_CHARS)))
                    r_store[r_wp[AW-1:0]] <= i_char;
            end else if (!r_ovf && r_wp < (AW+1)'(STORE_CHARS)) begin
                r_store[r_wp[AW-1:0]] <= i_char;
            end
        end
        if (i_cmd.zero) begin
            r_store[AW'(r_wp + 1'b1)] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash   <= '0;
            r_wp     <= '0;
            r_wb     <= '0;
            r_ovf    <= 1'b0;
            r_count  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_last   <= 1'b0;
            r_fail   <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if (i_cmd.accept) begin
                r_hash <= r_hash + HW'(fold_case(i_char));
                r_last <= i_last;
                r_hit  <= 1'b0;
                if (i_last) begin
                    r_fail <= r_ovf || ((r_wp + 1'b1) >= (AW+1)'(STORE_CHARS));
                end else if (!r_ovf && r_wp < (AW+1)'(STORE_CHARS)) begin
                    r_wp <= r_wp + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.reduce) r_hash <= r_hash - HW'(BUCKETS);
            if (i_cmd.hit) begin
                r_hit <= 1'b1;
                r_pos <= {1'b0, q_start};
            end
            if (i_cmd.insert) begin
                if (r_count >= (EW+1)'(MAX_ENTRIES)) begin
                    r_fail <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                    r_pos   <= r_wb;
                end
            end
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
                r_found  <= r_hit && !r_fail;
                r_opos   <= r_fail ? '0 : r_pos;
                r_obkt   <= r_hash;
                r_stat   <= r_fail;
                if (r_fail) begin
                    r_wp <= r_wb;
                end else begin
                    r_wp <= r_wp + 2'd2;
                    r_wb <= r_wp + 2'd2;
                end
                r_hash <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero) r_len <= r_wp + 1'b1 - r_wb;
        if (i_cmd.head_take) r_e <= r_head_q[EW-1:0];
        if (i_cmd.next_take) r_e <= q_next;
        if (i_cmd.cmp_start) r_i <= '0;
        if (i_cmd.cmp_next) r_i <= r_i + 1'b1;
    end

    assign pos_ext     = {{POSITION_W{1'b0}}, r_opos};
    assign bkt_ext     = {{BUCKET_W{1'b0}}, r_obkt};
    assign o_out_valid = r_ovalid;
    assign o_found     = r_found;
    assign o_position  = pos_ext[POSITION_W-1:0];
    assign o_bucket    = bkt_ext[BUCKET_W-1:0];
    assign o_fail      = r_stat;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (EW+1)'(MAX_ENTRIES))
        else $error("entry count past table size");
    a_wb_le_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb <= r_wp)
        else $error("word start past write position");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && r_ovalid |-> i_out_ready)
        else $error("result overwritten");
`endif

endmodule

// ===== verif/tb_identifier_intern_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_identifier_intern_hash_table_unit
// Streams identifiers one character per item into the intern table and checks
// each word result against a behavioral copy of the table: store fill, bucket
// hashing, case-insensitive chain lookup, overflow and full-table discards.
// ----------------------------------------------------------------------------
module tb_identifier_intern_hash_table_unit;
    import iiht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_CHARS = 1024;
    localparam int BUCKETS     = 100;
    localparam int MAX_ENTRIES = 512;
    localparam int WATCHDOG    = 200000;

    typedef struct {
        logic       found;
        logic [9:0] position;
        logic [6:0] bucket;
        logic       status;
    } t_word_result;

    class t_intern_scoreboard;
        logic [7:0]   store_bytes[STORE_CHARS];
        int           heads[BUCKETS];
        int           ent_start[MAX_ENTRIES];
        int           ent_len[MAX_ENTRIES];
        int           ent_next[MAX_ENTRIES];
        int           n_entries;
        int           wr_pos;
        int           begin_pos;
        int           sum;
        bit           ovf;
        t_word_result pending[$];
        int           errors;

        function new();
            foreach (heads[i]) heads[i] = -1;
            n_entries = 0; wr_pos = 0; begin_pos = 0; sum = 0; ovf = 0; errors = 0;
        endfunction

        function int lower(logic [7:0] c);
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return int'(c) + 32;
            return int'(c);
        endfunction

        function bit words_equal(int a, int b, int len);
            for (int i = 0; i < len; i++) begin
                if (a + i >= STORE_CHARS || b + i >= STORE_CHARS) return 0;
                if (lower(store_bytes[a+i]) != lower(store_bytes[b+i])) return 0;
            end
            return 1;
        endfunction

        function void note_char(logic [7:0] c, bit fin);
            t_word_result r;
            int len, e, steps;
            bit hit, fail;
            int pos;
            sum = (sum + lower(c)) % BUCKETS;
            if (!fin) begin
                if (!ovf && wr_pos < STORE_CHARS) begin
                    store_bytes[wr_pos] = c;
                    wr_pos++;
                end else begin
                    ovf = 1;
                end
                return;
            end
            hit = 0; pos = 0;
            fail = ovf || (wr_pos + 1 >= STORE_CHARS);
            if (!fail) begin
                store_bytes[wr_pos] = c;
                store_bytes[wr_pos+1] = 8'h00;
                len = wr_pos + 1 - begin_pos;
                e = heads[sum];
                steps = 0;
                while (e >= 0 && e < n_entries && steps < n_entries) begin
                    if (ent_len[e] == len && words_equal(ent_start[e], begin_pos, len)) begin
                        hit = 1;
                        pos = ent_start[e];
                        break;
                    end
                    e = ent_next[e];
                    steps++;
                end
                if (!hit) begin
                    if (n_entries >= MAX_ENTRIES) begin
                        fail = 1;
                    end else begin
                        ent_start[n_entries] = begin_pos;
                        ent_len[n_entries] = len;
                        ent_next[n_entries] = heads[sum];
                        heads[sum] = n_entries;
                        n_entries++;
                        pos = begin_pos;
                    end
                end
            end
            r.bucket = sum[6:0];
            if (fail) begin
                hit = 0; pos = 0;
                wr_pos = begin_pos;
            end else begin
                wr_pos += 2;
                begin_pos = wr_pos;
            end
            sum = 0;
            ovf = 0;
            r.found = hit;
            r.position = pos[9:0];
            r.status = fail;
            pending.push_back(r);
        endfunction

        function void check_word(logic [23:0] data, logic user);
            t_word_result x;
            if (pending.size() == 0) begin
                $error("unexpected result tdata=%h tuser=%b", data, user);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (data[0] !== x.found) begin
                $error("found exp %0d act %0d", x.found, data[0]); errors++;
            end
            if (data[10:1] !== x.position) begin
                $error("position exp %0d act %0d", x.position, data[10:1]); errors++;
            end
            if (data[17:11] !== x.bucket) begin
                $error("bucket exp %0d act %0d", x.bucket, data[17:11]); errors++;
            end
            if (user !== x.status) begin
                $error("status exp %0d act %0d", x.status, user); errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // char_code[7:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // found, position[9:0], bucket[6:0], zero pad
    logic        m_tuser;   // status

    identifier_intern_hash_table_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    t_intern_scoreboard sb = new();
    bit  calm;
    bit  hold_sink;
    int  idle_cycles;
    string vocab[$];

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) sb.note_char(s_tdata, s_tlast);
        if (i_rst_n && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_sink = 0;
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_char(logic [7:0] c, bit fin);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic send_word(string w);
        for (int i = 0; i < w.len(); i++) send_char(w[i], i == w.len() - 1);
    endtask

    function automatic string random_word(int n);
        string w = "";
        byte c;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: c = byte'($urandom_range(8'h41, 8'h5A));
                1: c = byte'($urandom_range(8'h61, 8'h7A));
                2: c = byte'($urandom_range(1, 255));
                default: c = byte'($urandom_range(8'h30, 8'h39));
            endcase
            w = {w, string'(c)};
        end
        return w;
    endfunction

    function automatic string flip_case(string w);
        string r = w;
        for (int i = 0; i < r.len(); i++) begin
            if ($urandom_range(0, 1)) begin
                if (r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
                else if (r[i] >= "A" && r[i] <= "Z") r[i] = r[i] + 8'd32;
            end
        end
        return r;
    endfunction

    initial begin
        int sent;
        string w;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        calm = 0; hold_sink = 0; idle_cycles = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word("A");
        send_word("a");
        send_word("Zz");
        send_word("zZ");
        send_char(8'hFF, 1'b0); send_char(8'h01, 1'b1);
        send_char(8'h5B, 1'b0); send_char(8'h40, 1'b1);
        send_word("d");
        send_char(8'h7F, 1'b0); send_char(8'h80, 1'b0); send_char(8'hAA, 1'b1);
        send_char(8'h55, 1'b1);
        send_word("ab"); send_word("ba");
        sent = 19;

        hold_sink = 1;
        for (int k = 0; k < 20; k++) send_word(random_word(2));
        sent += 40;

        while (sent < 1400) begin
            if (sent > 1150) calm = 1;
            if (vocab.size() > 0 && $urandom_range(0, 2) == 0) begin
                w = flip_case(vocab[$urandom_range(0, vocab.size() - 1)]);
            end else if ($urandom_range(0, 30) == 0) begin
                w = random_word($urandom_range(60, 200));
            end else begin
                w = random_word($urandom_range(1, 6));
                vocab.push_back(w);
            end
            send_word(w);
            sent += w.len();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
